// File: src/yuvrgb_pkg.sv
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared widths, register indexes, config/result types and luma tables for the
// yuv655 to RGB pixel converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    localparam int CODE_W  = 16;
    localparam int Y_W     = 6;
    localparam int CHR_W   = 5;
    localparam int COEF_W  = 17;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int FRAC_W  = 12;
    localparam int LUMA_W  = 20;
    localparam int ACC_W   = 24;
    localparam int Y_COUNT = 1 << Y_W;
    localparam int Y_MAX   = Y_COUNT - 1;

    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
    localparam logic [BYTE_W-1:0] BYTE_MAX   = '1;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_OUTPUT_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_V_TO_RED   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_U_TO_GREEN = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_V_TO_GREEN = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_U_TO_BLUE  = 3'd4;

    localparam logic [COEF_W-1:0] RST_COEF_V_TO_RED   = 17'd48811;
    localparam logic [COEF_W-1:0] RST_COEF_U_TO_GREEN = 17'd11982;
    localparam logic [COEF_W-1:0] RST_COEF_V_TO_GREEN = 17'd24863;
    localparam logic [COEF_W-1:0] RST_COEF_U_TO_BLUE  = 17'd61694;

    typedef enum logic {
        MODE_RGB    = 1'b0,
        MODE_NATIVE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             output_mode;
        logic [COEF_W-1:0] coef_v_to_red;
        logic [COEF_W-1:0] coef_u_to_green;
        logic [COEF_W-1:0] coef_v_to_green;
        logic [COEF_W-1:0] coef_u_to_blue;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] byte3;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } t_word;

    typedef logic [LUMA_W-1:0] t_luma_tab [Y_COUNT];
    typedef logic [BYTE_W-1:0] t_yb_tab   [Y_COUNT];

    // Q.12 luma, rounded to nearest: (Y*255*4096 + 31) / 63
    function automatic t_luma_tab f_build_luma();
        t_luma_tab tab;
        for (int y = 0; y < Y_COUNT; y++) begin
            tab[y] = LUMA_W'((y * 255 * 4096 + Y_MAX / 2) / Y_MAX);
        end
        return tab;
    endfunction

    // Truncated 8-bit luma for native mode: Y*255/63
    function automatic t_yb_tab f_build_yb();
        t_yb_tab tab;
        for (int y = 0; y < Y_COUNT; y++) begin
            tab[y] = BYTE_W'((y * 255) / Y_MAX);
        end
        return tab;
    endfunction

    localparam t_luma_tab LUMA_TAB = f_build_luma();
    localparam t_yb_tab   YB_TAB   = f_build_yb();

endpackage

// File: src/yuvrgb_cfg.sv
// ----------------------------------------------------------------------------
// yuvrgb_cfg
// Configuration register bank: mode bit and four Q5.12 coefficients.
// ----------------------------------------------------------------------------
module yuvrgb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [yuvrgb_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [yuvrgb_pkg::COEF_W-1:0] i_cfg_wdata,
    output yuvrgb_pkg::t_cfg              o_cfg
);
    import yuvrgb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUTPUT_MODE:     n_cfg.output_mode     = t_mode'(i_cfg_wdata[0]);
                REG_COEF_V_TO_RED:   n_cfg.coef_v_to_red   = i_cfg_wdata;
                REG_COEF_U_TO_GREEN: n_cfg.coef_u_to_green = i_cfg_wdata;
                REG_COEF_V_TO_GREEN: n_cfg.coef_v_to_green = i_cfg_wdata;
                REG_COEF_U_TO_BLUE:  n_cfg.coef_u_to_blue  = i_cfg_wdata;
                default:             n_cfg = r_cfg; // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_mode     <= MODE_RGB;
            r_cfg.coef_v_to_red   <= RST_COEF_V_TO_RED;
            r_cfg.coef_u_to_green <= RST_COEF_U_TO_GREEN;
            r_cfg.coef_v_to_green <= RST_COEF_V_TO_GREEN;
            r_cfg.coef_u_to_blue  <= RST_COEF_U_TO_BLUE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/yuvrgb_core.sv
// ----------------------------------------------------------------------------
// yuvrgb_core
// Single-pass conversion of one pixel code into a four-byte word.
// ----------------------------------------------------------------------------
module yuvrgb_core (
    input  logic [yuvrgb_pkg::CODE_W-1:0] i_code,
    input  yuvrgb_pkg::t_cfg              i_cfg,
    output yuvrgb_pkg::t_word             o_word
);
    import yuvrgb_pkg::*;

    logic [Y_W-1:0]          y;
    logic [CHR_W-1:0]        u_raw;
    logic [CHR_W-1:0]        v_raw;
    logic signed [ACC_W-1:0] u_s;
    logic signed [ACC_W-1:0] v_s;
    logic signed [ACC_W-1:0] luma;
    logic signed [ACC_W-1:0] c_vr;
    logic signed [ACC_W-1:0] c_ug;
    logic signed [ACC_W-1:0] c_vg;
    logic signed [ACC_W-1:0] c_ub;
    logic signed [ACC_W-1:0] sum_r;
    logic signed [ACC_W-1:0] sum_g;
    logic signed [ACC_W-1:0] sum_b;

    // Sign-extend a 5-bit chroma value; clamp the most negative code to -15
    function automatic logic signed [ACC_W-1:0] f_chroma(input logic [CHR_W-1:0] bits);
        logic [CHR_W-1:0] c;
        c = (bits == {1'b1, {(CHR_W-1){1'b0}}}) ? {1'b1, {(CHR_W-2){1'b0}}, 1'b1} : bits;
        return {{(ACC_W-CHR_W){c[CHR_W-1]}}, c};
    endfunction

    // Round Q.12 to nearest and saturate to 0..255
    function automatic logic [BYTE_W-1:0] f_to_byte(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] rnd;
        rnd = ACC_W'(acc) + ROUND_HALF;
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (|rnd[ACC_W-1:FRAC_W+BYTE_W]) begin
            return BYTE_MAX;
        end else begin
            return rnd[FRAC_W+BYTE_W-1:FRAC_W];
        end
    endfunction

    assign y     = i_code[CODE_W-1 -: Y_W];
    assign u_raw = i_code[2*CHR_W-1 -: CHR_W];
    assign v_raw = i_code[CHR_W-1:0];

    assign u_s  = f_chroma(u_raw);
    assign v_s  = f_chroma(v_raw);
    assign luma = {{(ACC_W-LUMA_W){1'b0}}, LUMA_TAB[y]};

    assign c_vr = {{(ACC_W-COEF_W){1'b0}}, i_cfg.coef_v_to_red};
    assign c_ug = {{(ACC_W-COEF_W){1'b0}}, i_cfg.coef_u_to_green};
    assign c_vg = {{(ACC_W-COEF_W){1'b0}}, i_cfg.coef_v_to_green};
    assign c_ub = {{(ACC_W-COEF_W){1'b0}}, i_cfg.coef_u_to_blue};

    assign sum_r = luma + v_s * c_vr;
    assign sum_g = luma - u_s * c_ug - v_s * c_vg;
    assign sum_b = luma + u_s * c_ub;

    always_comb begin
        case (i_cfg.output_mode)
            MODE_NATIVE: begin
                // offset binary: flip the sign bit, then shift left by 3
                o_word.byte0 = {~u_raw[CHR_W-1], u_raw[CHR_W-2:0], 3'b000};
                o_word.byte1 = YB_TAB[y];
                o_word.byte2 = {~v_raw[CHR_W-1], v_raw[CHR_W-2:0], 3'b000};
                o_word.byte3 = YB_TAB[y];
            end
            default: begin
                o_word.byte0 = f_to_byte(sum_b);
                o_word.byte1 = f_to_byte(sum_g);
                o_word.byte2 = f_to_byte(sum_r);
                o_word.byte3 = BYTE_MAX;
            end
        endcase
    end

endmodule

// File: src/yuv655_to_rgb_pixel_convert.sv
// ----------------------------------------------------------------------------
// yuv655_to_rgb_pixel_convert
// Top level: input register, single-pass conversion, result register.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request goes through the input register, then the
// result register. Throughput: 1 pixel per cycle while the output is taken;
// each register stalls only while the stage after it holds a request not taken.
// Reset: synchronous, active low; clears both valid flags, sets RGB mode and
// loads the default coefficients. No clearing pass.
// ----------------------------------------------------------------------------
module yuv655_to_rgb_pixel_convert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [yuvrgb_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [yuvrgb_pkg::COEF_W-1:0] i_cfg_wdata,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [yuvrgb_pkg::CODE_W-1:0] i_pixel_code,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [yuvrgb_pkg::BYTE_W-1:0] o_word_byte0,
    output logic [yuvrgb_pkg::BYTE_W-1:0] o_word_byte1,
    output logic [yuvrgb_pkg::BYTE_W-1:0] o_word_byte2,
    output logic [yuvrgb_pkg::BYTE_W-1:0] o_word_byte3
);
    import yuvrgb_pkg::*;

    t_cfg              cfg;
    t_word             word;

    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_out_valid;
    t_word             r_word;

    logic              out_load;
    logic              in_load;

    yuvrgb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    yuvrgb_core u_core (
        .i_code (r_code),
        .i_cfg  (cfg),
        .o_word (word)
    );

    // The result register takes a new word when it is empty or being drained.
    assign out_load = !r_out_valid || i_out_ready;
    // The input register advances whenever its content moves on (or it is empty).
    assign in_load  = !r_in_valid || out_load;

    assign o_in_ready = in_load;

    // Control: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: capture the request, then hold the converted word until taken
    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_code <= i_pixel_code;
        end
        if (out_load && r_in_valid) begin
            r_word <= word;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_byte0 = r_word.byte0;
    assign o_word_byte1 = r_word.byte1;
    assign o_word_byte2 = r_word.byte2;
    assign o_word_byte3 = r_word.byte3;

endmodule
